[sv/cpbps_pkg.sv]
package cpbps_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 256;
  localparam int unsigned COORD_BITS_DEF  = 24;

  localparam int unsigned DIST_BITS = 50;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_PROBE  = 2'd2,
    ACT_REPORT = 2'd3
  } action_e;

  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] sq_dist;
  } dist_res_t;

endpackage

[sv/cpbps_ram.sv]
module cpbps_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/cpbps_dist.sv]
module cpbps_dist import cpbps_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [3*COORD_BITS-1:0] probe_i,
  input  logic [3*COORD_BITS-1:0] point_i,
  output dist_res_t               res_o,
  output logic [3*COORD_BITS-1:0] match_o,
  output logic                    busy_o
);

  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned EXT_W = (SUM_W > DIST_BITS) ? SUM_W : DIST_BITS + 1;

  logic                    v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0]   abs_d [3];
  logic [COORD_BITS-1:0]   abs_q [3];
  logic [SQ_W-1:0]         sq_q  [3];
  logic [3*COORD_BITS-1:0] pt1_q, pt2_q, pt3_q;
  logic [DIST_BITS-1:0]    dist_d, dist_q;
  logic [SUM_W-1:0]        sum;
  logic [EXT_W-1:0]        sum_ext;

  always_comb begin
    logic [COORD_BITS:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff = {probe_i[k*COORD_BITS + COORD_BITS-1], probe_i[k*COORD_BITS +: COORD_BITS]}
           - {point_i[k*COORD_BITS + COORD_BITS-1], point_i[k*COORD_BITS +: COORD_BITS]};
      if (diff[COORD_BITS]) begin
        diff = ~diff + 1'b1;
      end
      abs_d[k] = diff[COORD_BITS-1:0];
    end
  end

  assign sum     = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  assign sum_ext = EXT_W'(sum);
  assign dist_d  = (sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      abs_q[k] <= abs_d[k];
      sq_q[k]  <= SQ_W'(abs_q[k]) * SQ_W'(abs_q[k]);
    end
    pt1_q  <= point_i;
    pt2_q  <= pt1_q;
    pt3_q  <= pt2_q;
    dist_q <= dist_d;
  end

  assign res_o.valid   = v3_q;
  assign res_o.sq_dist = dist_q;
  assign match_o       = pt3_q;
  assign busy_o        = v1_q | v2_q | v3_q;

endmodule

[sv/closest_pair_between_point_sets_top.sv]
// Closest pair between a stored set and a probed set of 3D points.
// Input channel (in_valid_i/in_ready_o) carries one request: an action and a
// point. A load writes the point into the point memory at the fill count; a
// load into a full store is dropped and sets the sticky overflow flag. A
// probe streams the stored points out of the point memory, one per cycle
// through the read port, into a three-stage squared-distance pipeline, and
// keeps the strictly closest pair. No request is taken while a probe scans
// or its results are still in the pipeline; a probe on an empty store does
// not start a scan.
// Output channel (out_valid_o/out_ready_i) carries one result per report,
// in the cycle after the report is accepted, from an output register. Loads,
// probes and clears are still taken while a result waits; a second report
// waits until the pending result has been taken.
// Reset clears the fill count, the best pair and the overflow flag; the
// point memory is not cleared, only entries below the fill count are read.
module closest_pair_between_point_sets_top import cpbps_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic signed [COORD_BITS-1:0] probe_x_o,
  output logic signed [COORD_BITS-1:0] probe_y_o,
  output logic signed [COORD_BITS-1:0] probe_z_o,
  output logic signed [COORD_BITS-1:0] match_x_o,
  output logic signed [COORD_BITS-1:0] match_y_o,
  output logic signed [COORD_BITS-1:0] match_z_o,
  output logic [DIST_BITS-1:0]         dist_squared_o,
  output logic                         overflow_o
);

  localparam int unsigned PT_W   = 3 * COORD_BITS;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     count_q, scan_idx_q;
  logic                 rd_valid_q;
  logic                 overflow_q;
  logic [PT_W-1:0]      probe_q;
  logic [DIST_BITS-1:0] best_dist_q;
  logic [PT_W-1:0]      best_probe_q, best_match_q;
  logic                 best_valid_q;
  logic                 out_valid_q, found_q, out_overflow_q;
  logic [PT_W-1:0]      out_probe_q, out_match_q;
  logic [DIST_BITS-1:0] out_dist_q;

  logic                 in_acc;
  action_e              action;
  logic [PT_W-1:0]      in_point;
  logic                 ram_we, ram_re;
  logic [PT_W-1:0]      ram_rdata;
  logic                 full;
  dist_res_t            res;
  logic [PT_W-1:0]      res_match;
  logic                 dist_busy;
  logic                 better;

  assign action   = action_e'(action_i);
  assign in_point = {pos_z_i, pos_y_i, pos_x_i};
  assign full     = (count_q == CNT_W'(STORE_DEPTH));

  assign in_ready_o = (state_q == ST_IDLE) && !rd_valid_q && !dist_busy
                      && !(out_valid_q && !out_ready_i && action == ACT_REPORT);
  assign in_acc     = in_valid_i && in_ready_o;

  assign ram_we = in_acc && (action == ACT_LOAD) && !full;
  assign ram_re = (state_q == ST_SCAN);

  cpbps_ram #(
    .WIDTH (PT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (in_point),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  cpbps_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_valid_q),
    .probe_i (probe_q),
    .point_i (ram_rdata),
    .res_o   (res),
    .match_o (res_match),
    .busy_o  (dist_busy)
  );

  assign better = res.valid && (!best_valid_q || (res.sq_dist < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      scan_idx_q     <= '0;
      rd_valid_q     <= 1'b0;
      overflow_q     <= 1'b0;
      probe_q        <= '0;
      best_dist_q    <= DIST_MAX;
      best_probe_q   <= '0;
      best_match_q   <= '0;
      best_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      found_q        <= 1'b0;
      out_probe_q    <= '0;
      out_match_q    <= '0;
      out_dist_q     <= '0;
      out_overflow_q <= 1'b0;
    end else begin
      rd_valid_q <= ram_re;
      if (out_valid_q && out_ready_i && !(in_acc && action == ACT_REPORT)) begin
        out_valid_q <= 1'b0;
      end
      if (better) begin
        best_dist_q  <= res.sq_dist;
        best_probe_q <= probe_q;
        best_match_q <= res_match;
        best_valid_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (action)
              ACT_CLEAR: begin
                count_q      <= '0;
                overflow_q   <= 1'b0;
                best_dist_q  <= DIST_MAX;
                best_probe_q <= '0;
                best_match_q <= '0;
                best_valid_q <= 1'b0;
              end
              ACT_LOAD: begin
                if (full) begin
                  overflow_q <= 1'b1;
                end else begin
                  count_q <= CNT_W'(count_q + 1'b1);
                end
              end
              ACT_PROBE: begin
                if (count_q != '0) begin
                  probe_q    <= in_point;
                  scan_idx_q <= '0;
                  state_q    <= ST_SCAN;
                end
              end
              ACT_REPORT: begin
                out_valid_q    <= 1'b1;
                found_q        <= best_valid_q;
                out_probe_q    <= best_valid_q ? best_probe_q : '0;
                out_match_q    <= best_valid_q ? best_match_q : '0;
                out_dist_q     <= best_valid_q ? best_dist_q : '0;
                out_overflow_q <= overflow_q;
                best_dist_q    <= DIST_MAX;
                best_probe_q   <= '0;
                best_match_q   <= '0;
                best_valid_q   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_idx_q <= CNT_W'(scan_idx_q + 1'b1);
          if (CNT_W'(scan_idx_q + 1'b1) == count_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign probe_x_o      = $signed(out_probe_q[0*COORD_BITS +: COORD_BITS]);
  assign probe_y_o      = $signed(out_probe_q[1*COORD_BITS +: COORD_BITS]);
  assign probe_z_o      = $signed(out_probe_q[2*COORD_BITS +: COORD_BITS]);
  assign match_x_o      = $signed(out_match_q[0*COORD_BITS +: COORD_BITS]);
  assign match_y_o      = $signed(out_match_q[1*COORD_BITS +: COORD_BITS]);
  assign match_z_o      = $signed(out_match_q[2*COORD_BITS +: COORD_BITS]);
  assign dist_squared_o = out_dist_q;
  assign overflow_o     = out_overflow_q;

  a_no_req_while_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || rd_valid_q || dist_busy) |-> !in_ready_o)
    else $error("request taken during a probe");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_idx_q < count_q))
    else $error("scan index beyond fill count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_report_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action == ACT_REPORT) |=> (out_valid_q && !best_valid_q))
    else $error("report did not raise a result");

  a_update_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    better |=> best_valid_q)
    else $error("best pair not marked valid after update");

endmodule

[dv/closest_pair_checker.sv]
module closest_pair_checker import cpbps_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [1:0]                       action_i,
  input  logic signed [COORD_BITS_DEF-1:0] pos_x_i,
  input  logic signed [COORD_BITS_DEF-1:0] pos_y_i,
  input  logic signed [COORD_BITS_DEF-1:0] pos_z_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic                             found_i,
  input  logic signed [COORD_BITS_DEF-1:0] probe_x_i,
  input  logic signed [COORD_BITS_DEF-1:0] probe_y_i,
  input  logic signed [COORD_BITS_DEF-1:0] probe_z_i,
  input  logic signed [COORD_BITS_DEF-1:0] match_x_i,
  input  logic signed [COORD_BITS_DEF-1:0] match_y_i,
  input  logic signed [COORD_BITS_DEF-1:0] match_z_i,
  input  logic [DIST_BITS-1:0]             dist_squared_i,
  input  logic                             overflow_i,
  output int unsigned                      fault_count_o,
  output int unsigned                      owed_o
);

  localparam int CB = COORD_BITS_DEF;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic                 found;
    point_t               probe;
    point_t               match;
    logic [DIST_BITS-1:0] sq_dist;
    logic                 overflow;
  } report_t;

  point_t               stored [STORE_DEPTH_DEF];
  int unsigned          fill;
  logic [DIST_BITS-1:0] best_dist;
  point_t               best_probe;
  point_t               best_match;
  logic                 best_ok;
  logic                 overflow_seen;
  report_t              report_q [$];
  report_t              want;
  point_t               req_point;

  task automatic clear_best();
    best_dist  = DIST_MAX;
    best_probe = '0;
    best_match = '0;
    best_ok    = 1'b0;
  endtask

  task automatic track_request(action_e act, point_t p);
    longint               dx;
    longint               dy;
    longint               dz;
    longint               sum;
    logic [DIST_BITS-1:0] d;
    report_t              r;
    case (act)
      ACT_CLEAR: begin
        fill          = 0;
        overflow_seen = 1'b0;
        clear_best();
      end
      ACT_LOAD: begin
        if (fill < STORE_DEPTH_DEF) begin
          stored[fill] = p;
          fill++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      ACT_PROBE: begin
        for (int i = 0; i < fill; i++) begin
          dx  = longint'($signed(p.x)) - longint'($signed(stored[i].x));
          dy  = longint'($signed(p.y)) - longint'($signed(stored[i].y));
          dz  = longint'($signed(p.z)) - longint'($signed(stored[i].z));
          sum = dx * dx + dy * dy + dz * dz;
          d   = (sum > longint'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
          if (!best_ok || d < best_dist) begin
            best_dist  = d;
            best_probe = p;
            best_match = stored[i];
            best_ok    = 1'b1;
          end
        end
      end
      ACT_REPORT: begin
        r.found    = best_ok;
        r.probe    = best_ok ? best_probe : '0;
        r.match    = best_ok ? best_match : '0;
        r.sq_dist  = best_ok ? best_dist : '0;
        r.overflow = overflow_seen;
        report_q.push_back(r);
        clear_best();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic signed [63:0] exp_v, logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      fault_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill          = 0;
      overflow_seen = 1'b0;
      clear_best();
      report_q.delete();
      owed_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          $error("result with no report pending");
          fault_count_o++;
        end else begin
          want = report_q.pop_front();
          check_field("found", want.found, found_i);
          check_field("probe_x", want.probe.x, probe_x_i);
          check_field("probe_y", want.probe.y, probe_y_i);
          check_field("probe_z", want.probe.z, probe_z_i);
          check_field("match_x", want.match.x, match_x_i);
          check_field("match_y", want.match.y, match_y_i);
          check_field("match_z", want.match.z, match_z_i);
          check_field("dist_squared", want.sq_dist, dist_squared_i);
          check_field("overflow", want.overflow, overflow_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        req_point = {pos_x_i, pos_y_i, pos_z_i};
        track_request(action_e'(action_i), req_point);
      end
      owed_o = report_q.size();
    end
  end

endmodule

[dv/closest_pair_between_point_sets_top_test.sv]
module closest_pair_between_point_sets_top_test;
  import cpbps_pkg::*;

  localparam int          CB             = COORD_BITS_DEF;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam coord_t COORD_TOP = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t COORD_BOT = {1'b1, {(CB-1){1'b0}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           action_i    = '0;
  coord_t               pos_x_i     = '0;
  coord_t               pos_y_i     = '0;
  coord_t               pos_z_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 found_o;
  coord_t               probe_x_o;
  coord_t               probe_y_o;
  coord_t               probe_z_o;
  coord_t               match_x_o;
  coord_t               match_y_o;
  coord_t               match_z_o;
  logic [DIST_BITS-1:0] dist_squared_o;
  logic                 overflow_o;

  int unsigned faults;
  int unsigned owed;
  int unsigned sent        = 0;
  bit          calm        = 1'b0;
  bit          hold_wanted = 1'b0;

  always #10 clk_i = ~clk_i;

  closest_pair_between_point_sets_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .probe_x_o      (probe_x_o),
    .probe_y_o      (probe_y_o),
    .probe_z_o      (probe_z_o),
    .match_x_o      (match_x_o),
    .match_y_o      (match_y_o),
    .match_z_o      (match_z_o),
    .dist_squared_o (dist_squared_o),
    .overflow_o     (overflow_o)
  );

  closest_pair_checker pair_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_i        (found_o),
    .probe_x_i      (probe_x_o),
    .probe_y_i      (probe_y_o),
    .probe_z_i      (probe_z_o),
    .match_x_i      (match_x_o),
    .match_y_i      (match_y_o),
    .match_z_i      (match_z_o),
    .dist_squared_i (dist_squared_o),
    .overflow_i     (overflow_o),
    .fault_count_o  (faults),
    .owed_o         (owed)
  );

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0, 1:    return coord_t'($urandom);
      2:       return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? COORD_TOP : COORD_BOT;
    endcase
  endfunction

  task automatic send_request(action_e act, coord_t x, coord_t y, coord_t z);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pos_x_i    <= x;
    pos_y_i    <= y;
    pos_z_i    <= z;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic run_episode(int unsigned most_loads);
    point_t      loaded [$];
    point_t      p;
    point_t      last_probe;
    int unsigned n_loads;
    int unsigned pick;
    if ($urandom_range(0, 3) != 0) send_request(ACT_CLEAR, rand_coord(), rand_coord(), rand_coord());
    n_loads = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, most_loads);
    repeat (n_loads) begin
      p = {rand_coord(), rand_coord(), rand_coord()};
      loaded.push_back(p);
      send_request(ACT_LOAD, p.x, p.y, p.z);
    end
    last_probe = {rand_coord(), rand_coord(), rand_coord()};
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_request(action_e'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord());
      end else begin
        if (pick < 4 || loaded.size() == 0) begin
          p = {rand_coord(), rand_coord(), rand_coord()};
        end else if (pick < 7) begin
          p   = loaded[$urandom_range(0, loaded.size() - 1)];
          p.x = p.x + coord_t'(int'($urandom_range(0, 4)) - 2);
        end else begin
          p = last_probe;
        end
        last_probe = p;
        send_request(ACT_PROBE, p.x, p.y, p.z);
      end
    end
    send_request(ACT_REPORT, rand_coord(), rand_coord(), rand_coord());
    if ($urandom_range(0, 3) == 0) send_request(ACT_REPORT, rand_coord(), rand_coord(), rand_coord());
  endtask

  // receiver: random stalls, one long hold-off, always ready once calm
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_wanted && out_valid_o) begin
        out_ready_i <= 1'b0;
        hold_wanted = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("closest_pair_between_point_sets_top regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_PROBE, '0, '0, '0);
    send_request(ACT_REPORT, COORD_TOP, COORD_BOT, '0);
    send_request(ACT_LOAD, COORD_TOP, COORD_TOP, COORD_TOP);
    send_request(ACT_LOAD, COORD_BOT, COORD_BOT, COORD_BOT);
    send_request(ACT_PROBE, COORD_TOP, COORD_TOP, COORD_TOP);
    send_request(ACT_PROBE, COORD_BOT, COORD_BOT, COORD_BOT);
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_CLEAR, '0, '0, '0);
    send_request(ACT_LOAD, COORD_BOT, COORD_BOT, COORD_BOT);
    send_request(ACT_PROBE, COORD_TOP, COORD_TOP, COORD_TOP);
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_CLEAR, '0, '0, '0);
    send_request(ACT_LOAD, coord_t'(256), '0, '0);
    send_request(ACT_LOAD, coord_t'(-256), '0, '0);
    send_request(ACT_PROBE, '0, '0, '0);
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_PROBE, coord_t'(1), coord_t'(-1), coord_t'(7));
    send_request(ACT_CLEAR, '0, '0, '0);
    send_request(ACT_REPORT, '0, '0, '0);

    // hold the output so a second report backs up the request channel
    hold_wanted = 1'b1;
    send_request(ACT_LOAD, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_PROBE, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_LOAD, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_PROBE, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_PROBE, rand_coord(), rand_coord(), rand_coord());

    while (sent < 150) run_episode(12);

    // fill the store past capacity
    send_request(ACT_CLEAR, '0, '0, '0);
    repeat (STORE_DEPTH_DEF + $urandom_range(1, 4))
      send_request(ACT_LOAD, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    repeat (3) send_request(ACT_PROBE, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_REPORT, '0, '0, '0);
    send_request(ACT_LOAD, rand_coord(), rand_coord(), rand_coord());
    send_request(ACT_REPORT, '0, '0, '0);

    while (sent < 480) run_episode(12);
    calm = 1'b1;
    while (sent < 550) run_episode(12);
    in_valid_i <= 1'b0;

    while (owed != 0) @(posedge clk_i);
    repeat (STORE_DEPTH_DEF + 16) @(posedge clk_i);
    if (faults == 0) begin
      $display("closest_pair_between_point_sets_top regression: pass");
    end else begin
      $display("closest_pair_between_point_sets_top regression: fail");
    end
    $finish;
  end

endmodule

[closest_pair_between_point_sets_top.f]
sv/cpbps_pkg.sv
sv/cpbps_ram.sv
sv/cpbps_dist.sv
sv/closest_pair_between_point_sets_top.sv
dv/closest_pair_checker.sv
dv/closest_pair_between_point_sets_top_test.sv
